// File: rtl/core/three_lepton_fake_matrix_weights_defines.svh
// assertion macros for the three-lepton fake weight block
`ifndef THREE_LEPTON_FAKE_MATRIX_WEIGHTS_DEFINES_SVH
`define THREE_LEPTON_FAKE_MATRIX_WEIGHTS_DEFINES_SVH

// same-cycle implication
`define TLFW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tlfw assertion failed");

// next-cycle implication
`define TLFW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tlfw assertion failed");

`endif

// File: rtl/core/tlfw_pkg.sv
// shared constants and types for the three-lepton fake weight block
`timescale 1ns / 1ps
package tlfw_pkg;
    localparam int RATE_BITS = 16;
    localparam int IN_W      = 16;
    localparam int MB_W      = RATE_BITS + 1;
    localparam int P_W       = IN_W + MB_W;
    localparam int Q_W       = 2 * P_W;
    localparam int T_W       = Q_W + P_W;
    localparam int TS_W      = T_W + 1;
    localparam int S_W       = TS_W + 2;
    localparam int D_W       = 3 * IN_W;
    localparam int QUO_W     = 33;
    localparam int DEN_SHIFT = 3 * RATE_BITS - 17;
    localparam int CMP_W     = D_W + DEN_SHIFT + QUO_W;
    localparam int W_W       = 32;
    localparam int NUM_LAT   = 7;
    localparam int DIV_LAT   = QUO_W;
    localparam int PIPE_LAT  = NUM_LAT + DIV_LAT;

    localparam logic [MB_W-1:0] ONE = MB_W'(1) << RATE_BITS;

    localparam int N_WGT       = 4;
    localparam int W_PROMPT    = 0;
    localparam int W_LIGHT     = 1;
    localparam int W_LIGHT_TAU = 2;
    localparam int W_TAU       = 3;

    typedef struct packed {
        logic valid;
        logic singular;
    } t_ctl;
endpackage

// File: rtl/core/tlfw_numer.sv
// product pipeline: class numerators and determinant magnitude
`timescale 1ns / 1ps
module tlfw_numer (
    input  logic                                           i_clk,
    input  logic                                           i_en,
    input  logic [2:0][tlfw_pkg::IN_W-1:0]                 i_real,
    input  logic [2:0][tlfw_pkg::IN_W-1:0]                 i_fake,
    input  logic [2:0]                                     i_pat,
    output logic [tlfw_pkg::N_WGT-1:0][tlfw_pkg::S_W-1:0]  o_num,
    output logic [tlfw_pkg::N_WGT-1:0]                     o_neg,
    output logic [tlfw_pkg::D_W-1:0]                       o_den
);
    // stage 1
    logic [2:0][1:0][tlfw_pkg::P_W-1:0] n_p1, r_p1;
    logic [2:0][1:0]                    n_s1, r_s1;
    logic [2:0][tlfw_pkg::IN_W-1:0]     n_dm1, r_dm1;
    logic                               n_dneg1, r_dneg1;
    // stage 2
    logic [3:0][tlfw_pkg::Q_W-1:0]      n_q2, r_q2;
    logic [3:0]                         n_sq2, r_sq2;
    logic [2*tlfw_pkg::IN_W-1:0]        n_d2, r_d2;
    logic [1:0][tlfw_pkg::P_W-1:0]      r_pt2;
    logic [1:0]                         r_st2;
    logic [tlfw_pkg::IN_W-1:0]          r_dmt2;
    logic                               r_dneg2;
    // stage 3
    logic [7:0][tlfw_pkg::Q_W-1:0]      n_lo3, r_lo3, n_hi3, r_hi3;
    logic [7:0]                         n_sg3, r_sg3;
    logic [tlfw_pkg::D_W-1:0]           n_d3, r_d3;
    logic                               r_dneg3;
    // stage 4
    logic [7:0][tlfw_pkg::T_W-1:0]      n_tm4, r_tm4;
    logic [7:0]                         r_sg4;
    logic [tlfw_pkg::D_W-1:0]           r_d4;
    logic                               r_dneg4;
    // stage 5
    logic signed [tlfw_pkg::TS_W-1:0]   n_ts5 [8];
    logic signed [tlfw_pkg::TS_W-1:0]   r_ts5 [8];
    logic [tlfw_pkg::D_W-1:0]           r_d5;
    logic                               r_dneg5;
    // stage 6
    logic signed [tlfw_pkg::S_W-1:0]    n_sum6 [tlfw_pkg::N_WGT];
    logic signed [tlfw_pkg::S_W-1:0]    r_sum6 [tlfw_pkg::N_WGT];
    logic [tlfw_pkg::D_W-1:0]           r_d6;
    logic                               r_dneg6;
    // stage 7
    logic [tlfw_pkg::N_WGT-1:0][tlfw_pkg::S_W-1:0] n_num7, r_num7;
    logic [tlfw_pkg::N_WGT-1:0]                    n_neg7, r_neg7;
    logic [tlfw_pkg::D_W-1:0]                      r_d7;

    // per-lepton factor products, both truth choices
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_p1[i][0] = tlfw_pkg::P_W'(i_real[i]) * tlfw_pkg::P_W'(i_pat[2-i] ?
                {1'b0, i_fake[i]} : tlfw_pkg::ONE - {1'b0, i_fake[i]});
            n_s1[i][0] = i_pat[2-i];
            n_p1[i][1] = tlfw_pkg::P_W'(i_fake[i]) * tlfw_pkg::P_W'(i_pat[2-i] ?
                {1'b0, i_real[i]} : tlfw_pkg::ONE - {1'b0, i_real[i]});
            n_s1[i][1] = !i_pat[2-i];
            n_dm1[i] = (i_real[i] >= i_fake[i]) ? i_real[i] - i_fake[i]
                                                : i_fake[i] - i_real[i];
        end
        n_dneg1 = (i_real[0] < i_fake[0]) ^ (i_real[1] < i_fake[1])
                ^ (i_real[2] < i_fake[2]);
    end

    always_comb begin
        for (int q = 0; q < 4; q++) begin
            n_q2[q]  = tlfw_pkg::Q_W'(r_p1[0][q/2]) * tlfw_pkg::Q_W'(r_p1[1][q%2]);
            n_sq2[q] = r_s1[0][q/2] ^ r_s1[1][q%2];
        end
        n_d2 = (2*tlfw_pkg::IN_W)'(r_dm1[0]) * (2*tlfw_pkg::IN_W)'(r_dm1[1]);
    end

    // split wide product into two partial products
    always_comb begin
        for (int c = 0; c < 8; c++) begin
            n_lo3[c] = tlfw_pkg::Q_W'(r_q2[c/2][tlfw_pkg::P_W-1:0])
                     * tlfw_pkg::Q_W'(r_pt2[c%2]);
            n_hi3[c] = tlfw_pkg::Q_W'(r_q2[c/2][tlfw_pkg::Q_W-1:tlfw_pkg::P_W])
                     * tlfw_pkg::Q_W'(r_pt2[c%2]);
            n_sg3[c] = r_sq2[c/2] ^ r_st2[c%2];
        end
        n_d3 = tlfw_pkg::D_W'(r_d2) * tlfw_pkg::D_W'(r_dmt2);
    end

    always_comb begin
        for (int c = 0; c < 8; c++) begin
            n_tm4[c] = (tlfw_pkg::T_W'(r_hi3[c]) << tlfw_pkg::P_W)
                     + tlfw_pkg::T_W'(r_lo3[c]);
        end
    end

    always_comb begin
        for (int c = 0; c < 8; c++) begin
            n_ts5[c] = r_sg4[c] ? -$signed({1'b0, r_tm4[c]}) : $signed({1'b0, r_tm4[c]});
        end
    end

    // class 0 prompt, class 1 fake tau, even classes above fake light, odd classes above fake light plus tau
    always_comb begin
        n_sum6[tlfw_pkg::W_PROMPT]    = tlfw_pkg::S_W'(r_ts5[0]);
        n_sum6[tlfw_pkg::W_TAU]       = tlfw_pkg::S_W'(r_ts5[1]);
        n_sum6[tlfw_pkg::W_LIGHT]     = tlfw_pkg::S_W'(r_ts5[2]) + tlfw_pkg::S_W'(r_ts5[4])
                                      + tlfw_pkg::S_W'(r_ts5[6]);
        n_sum6[tlfw_pkg::W_LIGHT_TAU] = tlfw_pkg::S_W'(r_ts5[3]) + tlfw_pkg::S_W'(r_ts5[5])
                                      + tlfw_pkg::S_W'(r_ts5[7]);
    end

    always_comb begin
        for (int w = 0; w < tlfw_pkg::N_WGT; w++) begin
            n_neg7[w] = r_sum6[w][tlfw_pkg::S_W-1] ^ r_dneg6;
            n_num7[w] = r_sum6[w][tlfw_pkg::S_W-1] ? -r_sum6[w] : r_sum6[w];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1    <= n_p1;
            r_s1    <= n_s1;
            r_dm1   <= n_dm1;
            r_dneg1 <= n_dneg1;

            r_q2    <= n_q2;
            r_sq2   <= n_sq2;
            r_d2    <= n_d2;
            r_pt2   <= r_p1[2];
            r_st2   <= r_s1[2];
            r_dmt2  <= r_dm1[2];
            r_dneg2 <= r_dneg1;

            r_lo3   <= n_lo3;
            r_hi3   <= n_hi3;
            r_sg3   <= n_sg3;
            r_d3    <= n_d3;
            r_dneg3 <= r_dneg2;

            r_tm4   <= n_tm4;
            r_sg4   <= r_sg3;
            r_d4    <= r_d3;
            r_dneg4 <= r_dneg3;

            r_ts5   <= n_ts5;
            r_d5    <= r_d4;
            r_dneg5 <= r_dneg4;

            r_sum6  <= n_sum6;
            r_d6    <= r_d5;
            r_dneg6 <= r_dneg5;

            r_num7  <= n_num7;
            r_neg7  <= n_neg7;
            r_d7    <= r_d6;
        end
    end

    assign o_num = r_num7;
    assign o_neg = r_neg7;
    assign o_den = r_d7;
endmodule

// File: rtl/core/tlfw_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module tlfw_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [tlfw_pkg::S_W-1:0]    i_num,
    input  logic [tlfw_pkg::D_W-1:0]    i_den,
    input  logic                        i_neg,
    output logic [tlfw_pkg::QUO_W-1:0]  o_quo,
    output logic                        o_sat,
    output logic                        o_neg
);
    logic [tlfw_pkg::S_W-1:0]   r_rem [tlfw_pkg::QUO_W];
    logic [tlfw_pkg::QUO_W-1:0] r_quo [tlfw_pkg::QUO_W];
    logic [tlfw_pkg::D_W-1:0]   r_den [tlfw_pkg::QUO_W];
    logic                       r_sat [tlfw_pkg::QUO_W];
    logic                       r_neg [tlfw_pkg::QUO_W];

    for (genvar s = 0; s < tlfw_pkg::QUO_W; s++) begin : g_stage
        localparam int K = tlfw_pkg::QUO_W - 1 - s;
        logic [tlfw_pkg::S_W-1:0]   rem_in;
        logic [tlfw_pkg::QUO_W-1:0] quo_in;
        logic [tlfw_pkg::D_W-1:0]   den_in;
        logic                       sat_in;
        logic                       neg_in;
        logic [tlfw_pkg::CMP_W-1:0] ext;
        logic                       ge;

        if (s == 0) begin : g_first
            // quotient too large for the output range
            assign sat_in = tlfw_pkg::CMP_W'(i_num) >=
                (tlfw_pkg::CMP_W'(i_den) << (tlfw_pkg::DEN_SHIFT + tlfw_pkg::QUO_W));
            assign rem_in = i_num;
            assign quo_in = '0;
            assign den_in = i_den;
            assign neg_in = i_neg;
        end else begin : g_next
            assign sat_in = r_sat[s-1];
            assign rem_in = r_rem[s-1];
            assign quo_in = r_quo[s-1];
            assign den_in = r_den[s-1];
            assign neg_in = r_neg[s-1];
        end

        assign ext = tlfw_pkg::CMP_W'(den_in) << (tlfw_pkg::DEN_SHIFT + K);
        assign ge  = tlfw_pkg::CMP_W'(rem_in) >= ext;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= ge ? rem_in - ext[tlfw_pkg::S_W-1:0] : rem_in;
                r_quo[s] <= {quo_in[tlfw_pkg::QUO_W-2:0], ge};
                r_den[s] <= den_in;
                r_sat[s] <= sat_in;
                r_neg[s] <= neg_in;
            end
        end
    end

    assign o_quo = r_quo[tlfw_pkg::QUO_W-1];
    assign o_sat = r_sat[tlfw_pkg::QUO_W-1];
    assign o_neg = r_neg[tlfw_pkg::QUO_W-1];
endmodule

// File: rtl/core/three_lepton_fake_matrix_weights.sv
// top level of the three-lepton matrix-method fake weight block
// path from input transfer to result on the output register:
// (7 product stages, 33 divider stages with one quotient bit each, output register)
// throughput: one event per cycle, every stage takes a new event each enabled cycle
// whole pipeline holds while the output register is full and stalled
// synchronous active-low reset clears all valid bits; no clearing pass
`timescale 1ns / 1ps
module three_lepton_fake_matrix_weights (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [tlfw_pkg::IN_W-1:0]           i_real_eff_first,
    input  logic [tlfw_pkg::IN_W-1:0]           i_real_eff_second,
    input  logic [tlfw_pkg::IN_W-1:0]           i_real_eff_third,
    input  logic [tlfw_pkg::IN_W-1:0]           i_fake_rate_first,
    input  logic [tlfw_pkg::IN_W-1:0]           i_fake_rate_second,
    input  logic [tlfw_pkg::IN_W-1:0]           i_fake_rate_third,
    input  logic [2:0]                          i_selection_type,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [tlfw_pkg::W_W-1:0]     o_weight_prompt,
    output logic signed [tlfw_pkg::W_W-1:0]     o_weight_fake_light,
    output logic signed [tlfw_pkg::W_W-1:0]     o_weight_fake_light_tau,
    output logic signed [tlfw_pkg::W_W-1:0]     o_weight_fake_tau,
    output logic                                o_singular
);
    logic                                           en;
    logic                                           singular_in;
    tlfw_pkg::t_ctl                                 r_ctl [tlfw_pkg::PIPE_LAT];
    logic [tlfw_pkg::N_WGT-1:0][tlfw_pkg::S_W-1:0]  num;
    logic [tlfw_pkg::N_WGT-1:0]                     num_neg;
    logic [tlfw_pkg::D_W-1:0]                       den;
    logic [tlfw_pkg::QUO_W-1:0]                     quo [tlfw_pkg::N_WGT];
    logic [tlfw_pkg::N_WGT-1:0]                     quo_sat;
    logic [tlfw_pkg::N_WGT-1:0]                     quo_neg;
    logic [tlfw_pkg::W_W-1:0]                       n_w [tlfw_pkg::N_WGT];
    logic [tlfw_pkg::W_W-1:0]                       r_w [tlfw_pkg::N_WGT];
    logic                                           r_out_valid;
    logic                                           r_singular;

    function automatic logic [tlfw_pkg::W_W-1:0] f_round_sat(
        input logic [tlfw_pkg::QUO_W-1:0] quo_v,
        input logic                       sat_v,
        input logic                       neg_v
    );
        logic [tlfw_pkg::QUO_W:0]   up;
        logic [tlfw_pkg::QUO_W-1:0] mag;
        logic                       big;
        logic [tlfw_pkg::QUO_W-1:0] negm;
        begin
            up   = {1'b0, quo_v} + 1'b1;
            mag  = up[tlfw_pkg::QUO_W:1];
            big  = sat_v || (mag >= (tlfw_pkg::QUO_W'(1) << (tlfw_pkg::W_W - 1)));
            negm = tlfw_pkg::QUO_W'(0) - mag;
            if (neg_v) begin
                f_round_sat = big ? {1'b1, {(tlfw_pkg::W_W-1){1'b0}}}
                                  : negm[tlfw_pkg::W_W-1:0];
            end else begin
                f_round_sat = big ? {1'b0, {(tlfw_pkg::W_W-1){1'b1}}}
                                  : mag[tlfw_pkg::W_W-1:0];
            end
        end
    endfunction

    assign en          = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign singular_in = (i_real_eff_first == i_fake_rate_first)
                      || (i_real_eff_second == i_fake_rate_second)
                      || (i_real_eff_third == i_fake_rate_third);

    tlfw_numer u_numer (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_real ({i_real_eff_third, i_real_eff_second, i_real_eff_first}),
        .i_fake ({i_fake_rate_third, i_fake_rate_second, i_fake_rate_first}),
        .i_pat  (i_selection_type),
        .o_num  (num),
        .o_neg  (num_neg),
        .o_den  (den)
    );

    for (genvar w = 0; w < tlfw_pkg::N_WGT; w++) begin : g_div
        tlfw_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (num[w]),
            .i_den (den),
            .i_neg (num_neg[w]),
            .o_quo (quo[w]),
            .o_sat (quo_sat[w]),
            .o_neg (quo_neg[w])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < tlfw_pkg::PIPE_LAT; j++) begin
                r_ctl[j] <= '0;
            end
        end else if (en) begin
            r_ctl[0] <= '{valid: i_in_valid, singular: singular_in};
            for (int j = 1; j < tlfw_pkg::PIPE_LAT; j++) begin
                r_ctl[j] <= r_ctl[j-1];
            end
        end
    end

    // singular events give zero weights
    always_comb begin
        for (int w = 0; w < tlfw_pkg::N_WGT; w++) begin
            n_w[w] = r_ctl[tlfw_pkg::PIPE_LAT-1].singular ? '0
                   : f_round_sat(quo[w], quo_sat[w], quo_neg[w]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_ctl[tlfw_pkg::PIPE_LAT-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w        <= n_w;
            r_singular <= r_ctl[tlfw_pkg::PIPE_LAT-1].singular;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_weight_prompt         = r_w[tlfw_pkg::W_PROMPT];
    assign o_weight_fake_light     = r_w[tlfw_pkg::W_LIGHT];
    assign o_weight_fake_light_tau = r_w[tlfw_pkg::W_LIGHT_TAU];
    assign o_weight_fake_tau       = r_w[tlfw_pkg::W_TAU];
    assign o_singular              = r_singular;
endmodule

// File: rtl/core/tlfw_checker.sv
// port-level checker for the three-lepton fake weight block, with bind
`timescale 1ns / 1ps
`include "three_lepton_fake_matrix_weights_defines.svh"
module tlfw_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic [tlfw_pkg::IN_W-1:0]        i_real_eff_first,
    input logic [tlfw_pkg::IN_W-1:0]        i_real_eff_second,
    input logic [tlfw_pkg::IN_W-1:0]        i_real_eff_third,
    input logic [tlfw_pkg::IN_W-1:0]        i_fake_rate_first,
    input logic [tlfw_pkg::IN_W-1:0]        i_fake_rate_second,
    input logic [tlfw_pkg::IN_W-1:0]        i_fake_rate_third,
    input logic [2:0]                       i_selection_type,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic signed [tlfw_pkg::W_W-1:0]  o_weight_prompt,
    input logic signed [tlfw_pkg::W_W-1:0]  o_weight_fake_light,
    input logic signed [tlfw_pkg::W_W-1:0]  o_weight_fake_light_tau,
    input logic signed [tlfw_pkg::W_W-1:0]  o_weight_fake_tau,
    input logic                             o_singular
);
    // input side holds back only behind a stalled full output
    `TLFW_ASSERT_NOW(a_stall_cause, o_in_stall, o_out_valid && i_out_stall)

    // singular transfer carries zero weights
    `TLFW_ASSERT_NOW(a_singular_zero, o_out_valid && o_singular,
        o_weight_prompt == 0 && o_weight_fake_light == 0 &&
        o_weight_fake_light_tau == 0 && o_weight_fake_tau == 0)

    // stalled result stays offered
    `TLFW_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)

    // stalled result keeps its prompt and fake-tau weights and its singular flag
    `TLFW_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall,
        $stable(o_weight_prompt) && $stable(o_weight_fake_tau) && $stable(o_singular))
endmodule

bind three_lepton_fake_matrix_weights tlfw_checker u_tlfw_checker (.*);
